// File: sv/sscp_pkg.sv
// Shared types for the segment pair closest-parameter unit.
`default_nettype none
package sscp_pkg;
	typedef enum logic [2:0] {
		PATH_BOTH_DEGEN   = 3'd0,
		PATH_FIRST_DEGEN  = 3'd1,
		PATH_SECOND_DEGEN = 3'd2,
		PATH_INTERIOR     = 3'd3,
		PATH_T_LOW        = 3'd4,
		PATH_T_HIGH       = 3'd5
	} path_code_t;
endpackage
`default_nettype wire

// File: sv/sscp_ifs.sv
// Channel interfaces: segment pair input and closest-parameter result.
`default_nettype none
interface sscp_pair_if #(parameter int COORD_BITS = 16) ();
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] first_start_x;
	logic signed [COORD_BITS-1:0] first_start_y;
	logic signed [COORD_BITS-1:0] first_end_x;
	logic signed [COORD_BITS-1:0] first_end_y;
	logic signed [COORD_BITS-1:0] second_start_x;
	logic signed [COORD_BITS-1:0] second_start_y;
	logic signed [COORD_BITS-1:0] second_end_x;
	logic signed [COORD_BITS-1:0] second_end_y;
	modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		second_start_x, second_start_y, second_end_x, second_end_y, input ready);
	modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
		second_start_x, second_start_y, second_end_x, second_end_y, output ready);
endinterface

interface sscp_res_if #(parameter int FRAC_BITS = 16) ();
	logic valid;
	logic ready;
	logic [FRAC_BITS:0] s_param;
	logic [FRAC_BITS:0] t_param;
	sscp_pkg::path_code_t path_code;
	modport source (output valid, s_param, t_param, path_code, input ready);
	modport sink (input valid, s_param, t_param, path_code, output ready);
endinterface
`default_nettype wire

// File: sv/sscp_qdiv.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module sscp_qdiv #(
	parameter int NW = 70,
	parameter int QW = 17
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [NW-1:0] den,
	output logic      [QW-1:0] quo
);
	logic [NW-1:0] rem_s [QW];
	logic [NW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	logic [NW-1:0] rem_d [QW];
	logic [NW-1:0] den_d [QW];
	logic [QW-1:0] quo_d [QW];

	// Stage i settles quotient bit QW-1-i against the shifted divisor.
	always_comb begin
		logic [NW-1:0] r;
		logic [NW-1:0] dv;
		logic [QW-1:0] q;
		logic [NW-1:0] sh;
		for (int i = 0; i < QW; i++) begin
			r  = (i == 0) ? num : rem_s[(i == 0) ? 0 : i - 1];
			dv = (i == 0) ? den : den_s[(i == 0) ? 0 : i - 1];
			q  = (i == 0) ? '0 : quo_s[(i == 0) ? 0 : i - 1];
			sh = dv << (QW - 1 - i);
			if (r >= sh) begin
				r = r - sh;
				q[QW-1-i] = 1'b1;
			end
			rem_d[i] = r;
			den_d[i] = dv;
			quo_d[i] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QW; i++) begin
				rem_s[i] <= rem_d[i];
				den_s[i] <= den_d[i];
				quo_s[i] <= quo_d[i];
			end
		end
	end

	assign quo = quo_s[QW-1];
endmodule
`default_nettype wire

// File: sv/segment_segment_closest_params_unit.sv
// Top level: closest-point parameters of two 2D segments, fully pipelined.
//
//   channel | direction | payload
//   pair    | in        | eight signed endpoint coordinates
//   result  | out       | s_param, t_param (unsigned Q1.FRAC_BITS), path_code
//
// One item per cycle enters while the result output is not stalled.
// The two chained divider ranks (four in parallel, then one), one quotient bit per stage, set the depth.
// A stall at the output freezes every stage together, so nothing is lost.
// Reset clears only the valid bits; the data registers are not reset.
`default_nettype none
module segment_segment_closest_params_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	sscp_pair_if.sink   pair,
	sscp_res_if.source  result
);
	import sscp_pkg::*;

	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW + 1;
	localparam int XW  = 2 * PW + 1;
	localparam int NW  = XW + FRAC_BITS + 1;
	localparam int QW  = FRAC_BITS + 1;
	localparam int MW  = PW + QW + 1;
	localparam int TW  = MW + 1;
	localparam logic [QW-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic          zero;
		logic          one;
		logic [NW-1:0] num;
		logic [NW-1:0] den;
	} lane_t;

	typedef struct packed {
		path_code_t          kind;
		logic [3:0]          zero;
		logic [3:0]          one;
		logic signed [PW-1:0] b;
		logic signed [PW-1:0] f;
		logic signed [PW-1:0] e;
	} side1_t;

	typedef struct packed {
		path_code_t    code;
		logic [QW-1:0] s_fin;
		logic [QW-1:0] t_fin;
	} side2_t;

	function automatic lane_t prep(input logic signed [XW-1:0] n,
			input logic signed [XW-1:0] d);
		lane_t l;
		l.zero = (n <= 0) || (d <= 0);
		l.one  = !l.zero && (n >= d);
		l.num  = (l.zero || l.one) ? '0 : (NW'(n) << FRAC_BITS);
		l.den  = (l.zero || l.one) ? NW'(1) : NW'(d);
		return l;
	endfunction

	function automatic logic [QW-1:0] pick(input logic zero, input logic one,
			input logic [QW-1:0] q);
		return zero ? '0 : (one ? Q_ONE : q);
	endfunction

	logic en;
	logic res_v_q;
	assign en = !res_v_q || result.ready;
	assign pair.ready = en;

	// Stage 1: edge and offset vectors.
	logic v_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	// Stage 2: dot products.
	logic v_s2;
	logic signed [PW-1:0] a_s2, b_s2, c_s2, e_s2, f_s2;
	// Stage 3: wide products.
	logic v_s3;
	logic signed [XW-1:0] ae_s3, bb_s3, bf_s3, ce_s3;
	logic signed [PW-1:0] a_s3, b_s3, c_s3, e_s3, f_s3;
	// Stage 4: denominator and s numerator.
	logic v_s4;
	logic signed [XW-1:0] d_s4, nsn_s4;
	logic signed [PW-1:0] a_s4, b_s4, c_s4, e_s4, f_s4;
	// Stage 5: divider lanes prepared.
	logic v_s5;
	lane_t lsg_s5, ls2_s5, ls5_s5, lt1_s5;
	side1_t sd_s5;

	logic   vd1_s [QW];
	side1_t sd1_s [QW];
	logic [QW-1:0] q_sg, q_s2, q_s5, q_t1, q_t;

	logic v_s6;
	side1_t sd_s6;
	logic [QW-1:0] sg_s6, s2_s6, s5_s6, t1_s6;
	logic v_s7;
	side1_t sd_s7;
	logic [QW-1:0] sg_s7, s2_s7, s5_s7, t1_s7;
	logic signed [MW-1:0] bs_s7;
	logic v_s8;
	side1_t sd_s8;
	logic [QW-1:0] sg_s8, s2_s8, s5_s8, t1_s8;
	logic signed [TW-1:0] n_s8;
	logic v_s9;
	side2_t sd_s9;
	logic [NW-1:0] tnum_s9, tden_s9;

	logic   vd2_s [QW];
	side2_t sd2_s [QW];

	logic [FRAC_BITS:0] s_q, t_q;
	path_code_t code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			res_v_q <= 1'b0;
			for (int i = 0; i < QW; i++) begin
				vd1_s[i] <= 1'b0;
				vd2_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vd1_s[0] <= v_s5;
			for (int i = 1; i < QW; i++) vd1_s[i] <= vd1_s[i-1];
			v_s6 <= vd1_s[QW-1];
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			vd2_s[0] <= v_s9;
			for (int i = 1; i < QW; i++) vd2_s[i] <= vd2_s[i-1];
			res_v_q <= vd2_s[QW-1];
		end
	end

	// Stage 5 lane preparation and kind of pair.
	lane_t lsg_d, ls2_d, ls5_d, lt1_d;
	side1_t sd_d;
	always_comb begin
		lsg_d = prep(nsn_s4, d_s4);
		ls2_d = prep(-XW'(c_s4), XW'(a_s4));
		ls5_d = prep(XW'(b_s4) - XW'(c_s4), XW'(a_s4));
		lt1_d = prep(XW'(f_s4), XW'(e_s4));
		if (a_s4 == '0 && e_s4 == '0) sd_d.kind = PATH_BOTH_DEGEN;
		else if (a_s4 == '0)          sd_d.kind = PATH_FIRST_DEGEN;
		else if (e_s4 == '0)          sd_d.kind = PATH_SECOND_DEGEN;
		else                          sd_d.kind = PATH_INTERIOR;
		sd_d.zero = {lt1_d.zero, ls5_d.zero, ls2_d.zero, lsg_d.zero};
		sd_d.one  = {lt1_d.one, ls5_d.one, ls2_d.one, lsg_d.one};
		sd_d.b = b_s4;
		sd_d.f = f_s4;
		sd_d.e = e_s4;
	end

	// Stage 9: pick the path and set up the t division.
	side2_t sd9_d;
	logic [NW-1:0] tnum_d, tden_d;
	always_comb begin
		logic neg, high;
		neg  = n_s8 < 0;
		high = n_s8 > (TW'(sd_s8.e) <<< FRAC_BITS);
		sd9_d.code  = sd_s8.kind;
		sd9_d.s_fin = sg_s8;
		sd9_d.t_fin = '0;
		tnum_d = '0;
		tden_d = NW'(1);
		case (sd_s8.kind)
			PATH_BOTH_DEGEN: begin
				sd9_d.s_fin = '0;
			end
			PATH_FIRST_DEGEN: begin
				sd9_d.s_fin = '0;
				sd9_d.t_fin = t1_s8;
			end
			PATH_SECOND_DEGEN: begin
				sd9_d.s_fin = s2_s8;
			end
			default: begin
				if (neg) begin
					sd9_d.code  = PATH_T_LOW;
					sd9_d.s_fin = s2_s8;
				end else if (high) begin
					sd9_d.code  = PATH_T_HIGH;
					sd9_d.s_fin = s5_s8;
					sd9_d.t_fin = Q_ONE;
				end else begin
					sd9_d.code = PATH_INTERIOR;
					tnum_d = NW'(n_s8);
					tden_d = NW'(sd_s8.e);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DW'(pair.first_end_x) - DW'(pair.first_start_x);
			uy_s1 <= DW'(pair.first_end_y) - DW'(pair.first_start_y);
			vx_s1 <= DW'(pair.second_end_x) - DW'(pair.second_start_x);
			vy_s1 <= DW'(pair.second_end_y) - DW'(pair.second_start_y);
			wx_s1 <= DW'(pair.first_start_x) - DW'(pair.second_start_x);
			wy_s1 <= DW'(pair.first_start_y) - DW'(pair.second_start_y);

			a_s2 <= PW'(ux_s1) * PW'(ux_s1) + PW'(uy_s1) * PW'(uy_s1);
			e_s2 <= PW'(vx_s1) * PW'(vx_s1) + PW'(vy_s1) * PW'(vy_s1);
			f_s2 <= PW'(vx_s1) * PW'(wx_s1) + PW'(vy_s1) * PW'(wy_s1);
			c_s2 <= PW'(ux_s1) * PW'(wx_s1) + PW'(uy_s1) * PW'(wy_s1);
			b_s2 <= PW'(ux_s1) * PW'(vx_s1) + PW'(uy_s1) * PW'(vy_s1);

			ae_s3 <= XW'(a_s2) * XW'(e_s2);
			bb_s3 <= XW'(b_s2) * XW'(b_s2);
			bf_s3 <= XW'(b_s2) * XW'(f_s2);
			ce_s3 <= XW'(c_s2) * XW'(e_s2);
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			c_s3 <= c_s2;
			e_s3 <= e_s2;
			f_s3 <= f_s2;

			d_s4   <= ae_s3 - bb_s3;
			nsn_s4 <= bf_s3 - ce_s3;
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			c_s4 <= c_s3;
			e_s4 <= e_s3;
			f_s4 <= f_s3;

			lsg_s5 <= lsg_d;
			ls2_s5 <= ls2_d;
			ls5_s5 <= ls5_d;
			lt1_s5 <= lt1_d;
			sd_s5  <= sd_d;

			sd1_s[0] <= sd_s5;
			for (int i = 1; i < QW; i++) sd1_s[i] <= sd1_s[i-1];

			sd_s6 <= sd1_s[QW-1];
			sg_s6 <= pick(sd1_s[QW-1].zero[0], sd1_s[QW-1].one[0], q_sg);
			s2_s6 <= pick(sd1_s[QW-1].zero[1], sd1_s[QW-1].one[1], q_s2);
			s5_s6 <= pick(sd1_s[QW-1].zero[2], sd1_s[QW-1].one[2], q_s5);
			t1_s6 <= pick(sd1_s[QW-1].zero[3], sd1_s[QW-1].one[3], q_t1);

			// The t numerator uses s in its quantized form.
			bs_s7 <= MW'(sd_s6.b) * MW'($signed({1'b0, sg_s6}));
			sd_s7 <= sd_s6;
			sg_s7 <= sg_s6;
			s2_s7 <= s2_s6;
			s5_s7 <= s5_s6;
			t1_s7 <= t1_s6;

			n_s8  <= TW'(bs_s7) + (TW'(sd_s7.f) <<< FRAC_BITS);
			sd_s8 <= sd_s7;
			sg_s8 <= sg_s7;
			s2_s8 <= s2_s7;
			s5_s8 <= s5_s7;
			t1_s8 <= t1_s7;

			sd_s9   <= sd9_d;
			tnum_s9 <= tnum_d;
			tden_s9 <= tden_d;

			sd2_s[0] <= sd_s9;
			for (int i = 1; i < QW; i++) sd2_s[i] <= sd2_s[i-1];

			code_q <= sd2_s[QW-1].code;
			s_q    <= sd2_s[QW-1].s_fin;
			t_q    <= (sd2_s[QW-1].code == PATH_INTERIOR) ? q_t : sd2_s[QW-1].t_fin;
		end
	end

	sscp_qdiv #(.NW(NW), .QW(QW)) u_div_sg (
		.clk(clk), .en(en), .num(lsg_s5.num), .den(lsg_s5.den), .quo(q_sg));
	sscp_qdiv #(.NW(NW), .QW(QW)) u_div_s2 (
		.clk(clk), .en(en), .num(ls2_s5.num), .den(ls2_s5.den), .quo(q_s2));
	sscp_qdiv #(.NW(NW), .QW(QW)) u_div_s5 (
		.clk(clk), .en(en), .num(ls5_s5.num), .den(ls5_s5.den), .quo(q_s5));
	sscp_qdiv #(.NW(NW), .QW(QW)) u_div_t1 (
		.clk(clk), .en(en), .num(lt1_s5.num), .den(lt1_s5.den), .quo(q_t1));
	sscp_qdiv #(.NW(NW), .QW(QW)) u_div_t (
		.clk(clk), .en(en), .num(tnum_s9), .den(tden_s9), .quo(q_t));

	assign result.valid     = res_v_q;
	assign result.s_param   = s_q;
	assign result.t_param   = t_q;
	assign result.path_code = code_q;
endmodule
`default_nettype wire

// File: dv/tb_segment_segment_closest_params_unit.sv
// Testbench for the segment pair closest-parameter unit: random and directed pairs checked.
`default_nettype none
module tb_segment_segment_closest_params_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import sscp_pkg::*;

	localparam int CB = 16;
	localparam int FB = 16;
	localparam logic [FB:0] Q_ONE = 17'h10000;
	localparam int N_RANDOM = 1030;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		coord_t fsx, fsy, fex, fey, ssx, ssy, sex, sey;
	} seg_pair_t;

	typedef struct {
		logic [FB:0] s;
		logic [FB:0] t;
		path_code_t code;
	} closest_t;

	logic clk;
	logic arst_n;

	sscp_pair_if #(.COORD_BITS(CB)) pair ();
	sscp_res_if #(.FRAC_BITS(FB)) result ();

	segment_segment_closest_params_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair),
		.result(result)
	);

	seg_pair_t pending_pairs[$];
	closest_t expected_params[$];
	seg_pair_t cur_pair;
	closest_t want_item;
	int n_sent;
	int n_recv;
	int n_total;
	int n_errors;
	int n_cycles;
	bit taken;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Clamped fixed-point quotient n/d, d > 0.
	function automatic logic [FB:0] clamp_quot(wide_t n, wide_t d);
		wide_t q;
		if (n <= 0)
			return '0;
		if (n >= d)
			return Q_ONE;
		q = (n <<< FB) / d;
		return q[FB:0];
	endfunction

	function automatic closest_t closest_params(seg_pair_t p);
		wide_t ux, uy, vx, vy, wx, wy, a, e, f, c, b, d, nt, lim, sw;
		closest_t r;
		ux = wide_t'(p.fex) - wide_t'(p.fsx);
		uy = wide_t'(p.fey) - wide_t'(p.fsy);
		vx = wide_t'(p.sex) - wide_t'(p.ssx);
		vy = wide_t'(p.sey) - wide_t'(p.ssy);
		wx = wide_t'(p.fsx) - wide_t'(p.ssx);
		wy = wide_t'(p.fsy) - wide_t'(p.ssy);
		a = ux * ux + uy * uy;
		e = vx * vx + vy * vy;
		f = vx * wx + vy * wy;
		c = ux * wx + uy * wy;
		b = ux * vx + uy * vy;
		r.s = '0;
		r.t = '0;
		if (a == 0 && e == 0) begin
			r.code = PATH_BOTH_DEGEN;
		end else if (a == 0) begin
			r.t = clamp_quot(f, e);
			r.code = PATH_FIRST_DEGEN;
		end else if (e == 0) begin
			r.s = clamp_quot(-c, a);
			r.code = PATH_SECOND_DEGEN;
		end else begin
			d = a * e - b * b;
			// Parallel pairs keep s at zero before the t step.
			if (d > 0)
				r.s = clamp_quot(b * f - c * e, d);
			sw = wide_t'({111'b0, r.s});
			nt = b * sw + (f <<< FB);
			lim = e <<< FB;
			if (nt < 0) begin
				r.s = clamp_quot(-c, a);
				r.code = PATH_T_LOW;
			end else if (nt > lim) begin
				r.t = Q_ONE;
				r.s = clamp_quot(b - c, a);
				r.code = PATH_T_HIGH;
			end else begin
				sw = nt / e;
				r.t = sw[FB:0];
				r.code = PATH_INTERIOR;
			end
		end
		return r;
	endfunction

	function automatic seg_pair_t mk(int a0, int a1, int a2, int a3, int b0, int b1, int b2,
		int b3);
		seg_pair_t p;
		p.fsx = coord_t'(a0); p.fsy = coord_t'(a1); p.fex = coord_t'(a2); p.fey = coord_t'(a3);
		p.ssx = coord_t'(b0); p.ssy = coord_t'(b1); p.sex = coord_t'(b2); p.sey = coord_t'(b3);
		return p;
	endfunction

	function automatic int rnd(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		int kind, span, ox, oy, dx, dy, m;
		kind = $urandom_range(9);
		span = ($urandom_range(1)) ? 16 : 2000;
		p = mk(rnd(span), rnd(span), rnd(span), rnd(span), rnd(span), rnd(span), rnd(span),
			rnd(span));
		case (kind) inside
			0, 1: begin
				p.fsx = coord_t'($urandom); p.fsy = coord_t'($urandom);
				p.fex = coord_t'($urandom); p.fey = coord_t'($urandom);
				p.ssx = coord_t'($urandom); p.ssy = coord_t'($urandom);
				p.sex = coord_t'($urandom); p.sey = coord_t'($urandom);
			end
			2: begin
				p.fex = p.fsx; p.fey = p.fsy;
			end
			3: begin
				p.sex = p.ssx; p.sey = p.ssy;
			end
			4: begin
				p.fex = p.fsx; p.fey = p.fsy; p.sex = p.ssx; p.sey = p.ssy;
			end
			5, 6: begin
				// Parallel or collinear second segment.
				dx = rnd(50); dy = rnd(50); m = rnd(3);
				ox = ($urandom_range(1)) ? 0 : rnd(20);
				oy = ($urandom_range(1)) ? 0 : rnd(20);
				p = mk(rnd(1000), rnd(1000), 0, 0, 0, 0, 0, 0);
				p.fex = p.fsx + coord_t'(dx); p.fey = p.fsy + coord_t'(dy);
				p.ssx = p.fsx + coord_t'(ox + rnd(3) * dx); p.ssy = p.fsy + coord_t'(oy + rnd(3) * dy);
				p.sex = p.ssx + coord_t'(m * dx); p.sey = p.ssy + coord_t'(m * dy);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_recv);
		n_errors++;
	endtask

	// Sender and receiver idle percentages follow the transfer count.
	function automatic int send_idle();
		if (n_sent < n_total / 3) return 15;
		if (n_sent < 2 * n_total / 3) return 45;
		return 0;
	endfunction

	function automatic int recv_idle();
		if (n_sent < n_total / 3) return 45;
		if (n_sent < 2 * n_total / 3) return 15;
		return 0;
	endfunction

	// Driver: presents the next pair and the receiver's ready at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			pair.valid = 1'b0;
			result.ready = 1'b0;
		end else begin
			if (!pair.valid || taken) begin
				if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle()) begin
					cur_pair = pending_pairs.pop_front();
					pair.first_start_x = cur_pair.fsx;
					pair.first_start_y = cur_pair.fsy;
					pair.first_end_x = cur_pair.fex;
					pair.first_end_y = cur_pair.fey;
					pair.second_start_x = cur_pair.ssx;
					pair.second_start_y = cur_pair.ssy;
					pair.second_end_x = cur_pair.sex;
					pair.second_end_y = cur_pair.sey;
					pair.valid = 1'b1;
				end else begin
					pair.valid = 1'b0;
				end
			end
			result.ready = ($urandom_range(99) >= recv_idle());
		end
	end

	// Monitor: records accepted pairs and checks each result transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			n_cycles++;
			taken = pair.valid && pair.ready;
			if (taken) begin
				expected_params.push_back(closest_params(cur_pair));
				n_sent++;
			end
			if (result.valid && result.ready) begin
				if (expected_params.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want_item = expected_params.pop_front();
					if (result.s_param !== want_item.s)
						report("s_param", int'(result.s_param), int'(want_item.s));
					if (result.t_param !== want_item.t)
						report("t_param", int'(result.t_param), int'(want_item.t));
					if (result.path_code !== want_item.code)
						report("path_code", int'(result.path_code), int'(want_item.code));
				end
				n_recv++;
			end
			if (n_recv >= n_total || n_cycles >= CYCLE_LIMIT) begin
				if (n_recv < n_total)
					report("results at cycle limit", n_recv, n_total);
				if (n_errors == 0)
					$display("PASSED: all results match");
				else
					$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		pair.valid = 1'b0;
		result.ready = 1'b0;
		taken = 1'b0;
		n_sent = 0;
		n_recv = 0;
		n_errors = 0;
		n_cycles = 0;
		pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(mk(5, 5, 5, 5, 0, 0, 10, 0));
		pending_pairs.push_back(mk(5, 5, 5, 5, 20, 0, 30, 0));
		pending_pairs.push_back(mk(0, 0, 10, 0, 3, 4, 3, 4));
		pending_pairs.push_back(mk(0, 0, 10, 0, -3, 4, -3, 4));
		pending_pairs.push_back(mk(-10, 0, 10, 0, 0, -10, 0, 10));
		pending_pairs.push_back(mk(0, 0, 10, 0, 0, 5, 10, 5));
		pending_pairs.push_back(mk(0, 0, 10, 0, 5, 0, 15, 0));
		pending_pairs.push_back(mk(0, 0, 10, 0, -15, 0, -5, 0));
		pending_pairs.push_back(mk(0, 0, 10, 0, 20, 5, 30, 5));
		pending_pairs.push_back(mk(0, 0, 10, 0, -30, 5, -20, 5));
		pending_pairs.push_back(mk(0, 0, 10, 0, 5, 3, 6, 20));
		pending_pairs.push_back(mk(0, 0, 10, 0, 5, -20, 6, -3));
		pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
		pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
		pending_pairs.push_back(mk(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768));
		pending_pairs.push_back(mk(-32768, 0, 32767, 0, -32768, 1, 32767, 1));
		pending_pairs.push_back(mk(0, -32768, 0, 32767, 32767, -32768, 32767, 32767));
		pending_pairs.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
		pending_pairs.push_back(mk(-32768, -32768, 32767, -32768, 32767, 32767, 32767, 32767));
		for (int i = 0; i < N_RANDOM; i++)
			pending_pairs.push_back(random_pair());
		n_total = pending_pairs.size();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end
endmodule
`default_nettype wire
